/* design/gsp_pkg.sv */
package gsp_pkg;

  localparam int RAD_W = 47;
  localparam int TOL_W = 21;
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] REG_RADIUS_X = 2'd0;
  localparam logic [IDX_W-1:0] REG_RADIUS_Y = 2'd1;
  localparam logic [IDX_W-1:0] REG_RADIUS_Z = 2'd2;
  localparam logic [IDX_W-1:0] REG_TOLERANCE = 2'd3;

  localparam logic [RAD_W-1:0] RADIUS_X_RST = 47'd6531212288;
  localparam logic [RAD_W-1:0] RADIUS_Y_RST = 47'd6531212288;
  localparam logic [RAD_W-1:0] RADIUS_Z_RST = 47'd6509314370;
  localparam logic [TOL_W-1:0] TOLERANCE_RST = 21'd110;

  localparam logic [1:0] STATUS_CONVERGED = 2'd0;
  localparam logic [1:0] STATUS_LIMIT = 2'd1;
  localparam logic [1:0] STATUS_ORIGIN = 2'd2;

  localparam logic [63:0] ONE20 = 64'd1 << 20;
  localparam logic [63:0] QONE = 64'd1 << 40;
  localparam logic [63:0] W_CAP = 64'd1 << 50;
  localparam logic [63:0] G_CAP = 64'd1 << 61;
  localparam logic [63:0] B_CAP = 64'd1 << 61;
  localparam logic [63:0] STEP_CAP = 64'd1 << 62;
  localparam logic [63:0] U_CAP = (64'd1 << 63) - 64'd1;

  localparam logic [6:0] SH_NONE = 7'd0;
  localparam logic [6:0] SH_U = 7'd20;
  localparam logic [6:0] SH_Q = 7'd40;
  localparam logic [6:0] SH_W = 7'd80;

  localparam logic [1:0] AX_LAST = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RMIN2, ST_RSQ, ST_KQ, ST_U, ST_UU, ST_GSQ, ST_LL, ST_LSQ,
    ST_PK, ST_PP, ST_MSQ, ST_R, ST_BM, ST_DL, ST_OFF, ST_RD, ST_W, ST_T,
    ST_TK, ST_GT, ST_CHK, ST_OUT, ST_DONE
  } gsp_state_t;

  typedef struct packed {
    logic [127:0] num;
    logic [6:0]   sh;
    logic [127:0] den;
    logic [63:0]  cap;
  } div_req_t;

endpackage

/* design/gsp_mul.sv */
module gsp_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);

  logic [63:0] a_r, b_r;
  logic [2:0]  cnt;
  logic        run, pv;
  logic [63:0] pp;
  logic [1:0]  psh;
  logic [31:0] a_half, b_half;

  assign a_half = cnt[0] ? a_r[63:32] : a_r[31:0];
  assign b_half = cnt[1] ? b_r[63:32] : b_r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      pv <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        pv <= 1'b0;
        cnt <= '0;
      end else if (run) begin
        pv <= (cnt != 3'd4);
        if (cnt != 3'd4) cnt <= cnt + 3'd1;
        if (cnt == 3'd4 && pv) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      prod <= '0;
    end else if (run) begin
      if (cnt != 3'd4) begin
        pp <= a_half * b_half;
        psh <= {1'b0, cnt[0]} + {1'b0, cnt[1]};
      end
      if (pv) prod <= prod + ({64'b0, pp} << {psh, 5'b0});
    end
  end

endmodule

/* design/gsp_div.sv */
module gsp_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  gsp_pkg::div_req_t req,
  output logic              done,
  output logic [63:0]       q
);

  logic [191:0] n_full;
  logic [127:0] rem, den_r;
  logic [63:0]  low, qr, cap_r;
  logic [5:0]   cnt;
  logic         run, sat;
  logic [128:0] trial;
  logic         ge;

  assign n_full = {64'b0, req.num} << req.sh;
  assign trial = {rem, low[63]} - {1'b0, den_r};
  assign ge = !trial[128];
  assign q = sat ? cap_r : ((qr > cap_r) ? cap_r : qr);

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (sat || cnt == 6'd63) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sat <= (n_full[191:64] >= req.den);
      rem <= n_full[191:64];
      low <= n_full[63:0];
      den_r <= req.den;
      cap_r <= req.cap;
      qr <= '0;
    end else if (run && !sat) begin
      rem <= ge ? trial[127:0] : {rem[126:0], low[63]};
      low <= {low[62:0], 1'b0};
      qr <= {qr[62:0], ge};
    end
  end

endmodule

/* design/gsp_sqrt.sv */
module gsp_sqrt (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] x,
  output logic         done,
  output logic [63:0]  root
);

  logic [127:0] xr;
  logic [65:0]  rem;
  logic [5:0]   cnt;
  logic         run;
  logic [67:0]  rem_sh, trial;
  logic         ge;

  assign rem_sh = {rem, xr[127:126]};
  assign trial = {2'b0, root, 2'b01};
  assign ge = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr <= x;
      rem <= '0;
      root <= '0;
    end else if (run) begin
      xr <= {xr[125:0], 2'b00};
      rem <= ge ? 66'(rem_sh - trial) : rem_sh[65:0];
      root <= {root[62:0], ge};
    end
  end

endmodule

/* design/geodetic_surface_projection_core.sv */
// Projects a point along the ellipsoid normal onto the surface set by the
// three radius registers. Pulse start while busy is low to hand in an item;
// busy stays high until the result appears for one cycle with done high, and
// the result must be taken in that cycle since it cannot be held back. An item
// at the origin goes from idle straight to the done state. Any other item
// runs up to MAX_STEPS Newton steps, and the next item is taken only once
// it is done; a division whose quotient saturates ends early. Every division
// goes through the bit-serial divider, one quotient bit per cycle, and every
// root through the square root, one root bit per cycle, one after another.
// Registers may be written at any time the block is idle; writes are always
// taken.
module geodetic_surface_projection_core #(
  parameter int MAX_STEPS = 8,
  parameter int COORD_WIDTH = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gsp_pkg::IDX_W-1:0]     cfg_index,
  input  logic [gsp_pkg::RAD_W-1:0]     cfg_data,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] surface_x,
  output logic signed [COORD_WIDTH-1:0] surface_y,
  output logic signed [COORD_WIDTH-1:0] surface_z,
  output logic [3:0]                    steps_used,
  output logic [1:0]                    status
);

  localparam int SW = $clog2(MAX_STEPS + 1);

  gsp_pkg::gsp_state_t state, state_next;
  logic issued, issued_next;

  logic [gsp_pkg::RAD_W-1:0] radius_x, radius_y, radius_z;
  logic [gsp_pkg::TOL_W-1:0] residual_tolerance;

  logic [63:0] rad [3];
  logic [63:0] rmin;
  logic [COORD_WIDTH-1:0] pin [3];
  logic [COORD_WIDTH-1:0] abs_in [3];
  logic [63:0] mag_in [3];
  logic origin_in;

  logic [63:0] mag [3];
  logic        pneg [3];
  logic [40:0] kq [3];
  logic [63:0] dmag [3];
  logic        dneg [3];
  logic [COORD_WIDTH-1:0] surf [3];

  logic [1:0]    ax;
  logic [SW-1:0] steps;
  logic          origin;
  logic [127:0]  rmin2, tmp128, acc;
  logic [63:0]   tmp64, gval, lval, mval, rval, tsum;
  logic signed [63:0] b, g, s;

  logic         mul_start, div_start, sqrt_start;
  logic [63:0]  mul_a, mul_b;
  logic         mul_done, div_done, sqrt_done;
  logic [127:0] mul_prod, sqrt_x;
  logic [63:0]  div_q, sqrt_root;
  gsp_pkg::div_req_t div_req;

  logic [63:0] diff, bm_raw, bm, s_mag, g_mag, b_mag, off, d_abs, t_val, half, ocap;
  logic signed [63:0] b_init, b_sum, b_clamp, d_val;
  logic rneg, cont, last;
  logic [COORD_WIDTH-1:0] q_cw, surf_val;
  logic [SW+3:0] steps_wide;

  gsp_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  gsp_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .req(div_req),
    .done(div_done), .q(div_q)
  );

  gsp_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .x(sqrt_x),
    .done(sqrt_done), .root(sqrt_root)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_x <= gsp_pkg::RADIUS_X_RST;
      radius_y <= gsp_pkg::RADIUS_Y_RST;
      radius_z <= gsp_pkg::RADIUS_Z_RST;
      residual_tolerance <= gsp_pkg::TOLERANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gsp_pkg::REG_RADIUS_X: radius_x <= cfg_data;
        gsp_pkg::REG_RADIUS_Y: radius_y <= cfg_data;
        gsp_pkg::REG_RADIUS_Z: radius_z <= cfg_data;
        gsp_pkg::REG_TOLERANCE: residual_tolerance <= cfg_data[gsp_pkg::TOL_W-1:0];
        default: residual_tolerance <= residual_tolerance;
      endcase
    end
  end

  assign pin[0] = point_x;
  assign pin[1] = point_y;
  assign pin[2] = point_z;

  always_comb begin
    rad[0] = (radius_x == '0) ? 64'd1 : 64'(radius_x);
    rad[1] = (radius_y == '0) ? 64'd1 : 64'(radius_y);
    rad[2] = (radius_z == '0) ? 64'd1 : 64'(radius_z);
    rmin = rad[0];
    if (rad[1] < rmin) rmin = rad[1];
    if (rad[2] < rmin) rmin = rad[2];
    for (int i = 0; i < 3; i++) begin
      abs_in[i] = pin[i][COORD_WIDTH-1] ? -pin[i] : pin[i];
      mag_in[i] = 64'(abs_in[i]);
    end
    origin_in = (mag_in[0] == '0) && (mag_in[1] == '0) && (mag_in[2] == '0);
  end

  always_comb begin
    last = (ax == gsp_pkg::AX_LAST);
    diff = (gval >= gsp_pkg::ONE20) ? gval - gsp_pkg::ONE20 : gsp_pkg::ONE20 - gval;
    bm_raw = mul_prod[83:20];
    bm = (bm_raw > gsp_pkg::B_CAP) ? gsp_pkg::B_CAP : bm_raw;
    b_init = (gval >= gsp_pkg::ONE20) ? $signed(bm) : -$signed(bm);
    s_mag = s[63] ? 64'(-s) : 64'(s);
    g_mag = g[63] ? 64'(-g) : 64'(g);
    b_mag = b[63] ? 64'(-b) : 64'(b);
    b_sum = (s[63] == g[63]) ? b + $signed(div_q) : b - $signed(div_q);
    if (b_sum > $signed(gsp_pkg::B_CAP)) b_clamp = $signed(gsp_pkg::B_CAP);
    else if (b_sum < -$signed(gsp_pkg::B_CAP)) b_clamp = -$signed(gsp_pkg::B_CAP);
    else b_clamp = b_sum;
    off = mul_prod[103:40];
    d_val = b[63] ? $signed(gsp_pkg::QONE - off) : $signed(gsp_pkg::QONE + off);
    d_abs = d_val[63] ? 64'(-d_val) : 64'(d_val);
    if (d_abs == '0) d_abs = 64'd1;
    t_val = mul_prod[103:40];
    half = 64'd1 << (COORD_WIDTH - 1);
    rneg = pneg[ax] ^ dneg[ax];
    ocap = rneg ? half : half - 64'd1;
    q_cw = div_q[COORD_WIDTH-1:0];
    surf_val = rneg ? -q_cw : q_cw;
    cont = (s_mag > 64'(residual_tolerance)) && (steps < SW'(MAX_STEPS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsp_pkg::ST_IDLE;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      issued <= issued_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start = 1'b0;
    div_start = 1'b0;
    sqrt_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    div_req = '0;
    sqrt_x = acc;
    unique case (state)
      gsp_pkg::ST_IDLE: begin
        if (start) state_next = origin_in ? gsp_pkg::ST_DONE : gsp_pkg::ST_RMIN2;
      end
      gsp_pkg::ST_RMIN2: begin
        mul_a = rmin; mul_b = rmin; mul_start = !issued;
        if (mul_done) state_next = gsp_pkg::ST_RSQ;
      end
      gsp_pkg::ST_RSQ: begin
        mul_a = rad[ax]; mul_b = rad[ax]; mul_start = !issued;
        if (mul_done) state_next = gsp_pkg::ST_KQ;
      end
      gsp_pkg::ST_KQ: begin
        div_req = '{num: rmin2, sh: gsp_pkg::SH_Q, den: tmp128, cap: gsp_pkg::QONE};
        div_start = !issued;
        if (div_done) state_next = last ? gsp_pkg::ST_U : gsp_pkg::ST_RSQ;
      end
      gsp_pkg::ST_U: begin
        div_req = '{num: {64'b0, mag[ax]}, sh: gsp_pkg::SH_U, den: {64'b0, rad[ax]},
                    cap: gsp_pkg::U_CAP};
        div_start = !issued;
        if (div_done) state_next = gsp_pkg::ST_UU;
      end
      gsp_pkg::ST_UU: begin
        mul_a = tmp64; mul_b = tmp64; mul_start = !issued;
        if (mul_done) state_next = last ? gsp_pkg::ST_GSQ : gsp_pkg::ST_U;
      end
      gsp_pkg::ST_GSQ: begin
        sqrt_start = !issued;
        if (sqrt_done) state_next = gsp_pkg::ST_LL;
      end
      gsp_pkg::ST_LL: begin
        mul_a = mag[ax]; mul_b = mag[ax]; mul_start = !issued;
        if (mul_done) state_next = last ? gsp_pkg::ST_LSQ : gsp_pkg::ST_LL;
      end
      gsp_pkg::ST_LSQ: begin
        sqrt_start = !issued;
        if (sqrt_done) state_next = gsp_pkg::ST_PK;
      end
      gsp_pkg::ST_PK: begin
        mul_a = mag[ax]; mul_b = 64'(kq[ax]); mul_start = !issued;
        if (mul_done) state_next = gsp_pkg::ST_PP;
      end
      gsp_pkg::ST_PP: begin
        mul_a = tmp64; mul_b = tmp64; mul_start = !issued;
        if (mul_done) state_next = last ? gsp_pkg::ST_MSQ : gsp_pkg::ST_PK;
      end
      gsp_pkg::ST_MSQ: begin
        sqrt_start = !issued;
        if (sqrt_done) state_next = gsp_pkg::ST_R;
      end
      gsp_pkg::ST_R: begin
        div_req = '{num: {64'b0, lval}, sh: gsp_pkg::SH_Q, den: {64'b0, mval},
                    cap: gsp_pkg::G_CAP};
        div_start = !issued;
        if (div_done) state_next = gsp_pkg::ST_BM;
      end
      gsp_pkg::ST_BM: begin
        mul_a = diff; mul_b = rval; mul_start = !issued;
        if (mul_done) state_next = gsp_pkg::ST_OFF;
      end
      gsp_pkg::ST_DL: begin
        div_req = '{num: {64'b0, s_mag}, sh: gsp_pkg::SH_Q,
                    den: {64'b0, g_mag[62:0], 1'b0}, cap: gsp_pkg::STEP_CAP};
        div_start = !issued;
        if (div_done) state_next = gsp_pkg::ST_OFF;
      end
      gsp_pkg::ST_OFF: begin
        mul_a = b_mag; mul_b = 64'(kq[ax]); mul_start = !issued;
        if (mul_done) state_next = gsp_pkg::ST_RD;
      end
      gsp_pkg::ST_RD: begin
        mul_a = rad[ax]; mul_b = dmag[ax]; mul_start = !issued;
        if (mul_done) state_next = gsp_pkg::ST_W;
      end
      gsp_pkg::ST_W: begin
        div_req = '{num: {64'b0, mag[ax]}, sh: gsp_pkg::SH_W, den: tmp128,
                    cap: gsp_pkg::W_CAP};
        div_start = !issued;
        if (div_done) state_next = gsp_pkg::ST_T;
      end
      gsp_pkg::ST_T: begin
        mul_a = tmp64; mul_b = tmp64; mul_start = !issued;
        if (mul_done) state_next = gsp_pkg::ST_TK;
      end
      gsp_pkg::ST_TK: begin
        mul_a = tmp64; mul_b = 64'(kq[ax]); mul_start = !issued;
        if (mul_done) state_next = gsp_pkg::ST_GT;
      end
      gsp_pkg::ST_GT: begin
        div_req = '{num: tmp128, sh: gsp_pkg::SH_NONE, den: {64'b0, dmag[ax]},
                    cap: gsp_pkg::G_CAP};
        div_start = !issued;
        if (div_done) state_next = last ? gsp_pkg::ST_CHK : gsp_pkg::ST_OFF;
      end
      gsp_pkg::ST_CHK: begin
        if (!cont) state_next = gsp_pkg::ST_OUT;
        else if (g != '0) state_next = gsp_pkg::ST_DL;
        else state_next = gsp_pkg::ST_OFF;
      end
      gsp_pkg::ST_OUT: begin
        div_req = '{num: {64'b0, mag[ax]}, sh: gsp_pkg::SH_Q, den: {64'b0, dmag[ax]},
                    cap: ocap};
        div_start = !issued;
        if (div_done) state_next = last ? gsp_pkg::ST_DONE : gsp_pkg::ST_OUT;
      end
      gsp_pkg::ST_DONE: begin
        state_next = gsp_pkg::ST_IDLE;
      end
      default: state_next = gsp_pkg::ST_IDLE;
    endcase
    if (mul_done || div_done || sqrt_done) issued_next = 1'b0;
    else if (mul_start || div_start || sqrt_start) issued_next = 1'b1;
    else issued_next = issued;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      gsp_pkg::ST_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag_in[i];
            pneg[i] <= pin[i][COORD_WIDTH-1];
            surf[i] <= '0;
          end
          origin <= origin_in;
          steps <= '0;
          ax <= '0;
        end
      end
      gsp_pkg::ST_RMIN2: if (mul_done) rmin2 <= mul_prod;
      gsp_pkg::ST_RSQ: if (mul_done) tmp128 <= mul_prod;
      gsp_pkg::ST_KQ: begin
        if (div_done) begin
          kq[ax] <= div_q[40:0];
          ax <= last ? 2'd0 : ax + 2'd1;
          if (last) acc <= '0;
        end
      end
      gsp_pkg::ST_U: if (div_done) tmp64 <= div_q;
      gsp_pkg::ST_PK: if (mul_done) tmp64 <= mul_prod[103:40];
      gsp_pkg::ST_UU, gsp_pkg::ST_LL, gsp_pkg::ST_PP: begin
        if (mul_done) begin
          acc <= acc + mul_prod;
          ax <= last ? 2'd0 : ax + 2'd1;
        end
      end
      gsp_pkg::ST_GSQ: begin
        if (sqrt_done) begin
          gval <= sqrt_root;
          acc <= '0;
        end
      end
      gsp_pkg::ST_LSQ: begin
        if (sqrt_done) begin
          lval <= sqrt_root;
          acc <= '0;
        end
      end
      gsp_pkg::ST_MSQ: if (sqrt_done) mval <= (sqrt_root == '0) ? 64'd1 : sqrt_root;
      gsp_pkg::ST_R: if (div_done) rval <= div_q;
      gsp_pkg::ST_BM: begin
        if (mul_done) begin
          b <= b_init;
          g <= '0;
          tsum <= '0;
          ax <= '0;
        end
      end
      gsp_pkg::ST_DL: begin
        if (div_done) begin
          b <= b_clamp;
          g <= '0;
        end
      end
      gsp_pkg::ST_OFF: begin
        if (mul_done) begin
          dneg[ax] <= d_val[63];
          dmag[ax] <= d_abs;
        end
      end
      gsp_pkg::ST_RD, gsp_pkg::ST_TK: if (mul_done) tmp128 <= mul_prod;
      gsp_pkg::ST_W: if (div_done) tmp64 <= div_q;
      gsp_pkg::ST_T: begin
        if (mul_done) begin
          tmp64 <= t_val;
          tsum <= tsum + t_val;
        end
      end
      gsp_pkg::ST_GT: begin
        if (div_done) begin
          g <= dneg[ax] ? g - $signed(div_q) : g + $signed(div_q);
          ax <= last ? 2'd0 : ax + 2'd1;
          if (last) begin
            s <= $signed(tsum - gsp_pkg::QONE);
            steps <= steps + SW'(1);
          end
        end
      end
      gsp_pkg::ST_CHK: begin
        ax <= '0;
        tsum <= '0;
      end
      gsp_pkg::ST_OUT: begin
        if (div_done) begin
          surf[ax] <= surf_val;
          ax <= last ? 2'd0 : ax + 2'd1;
        end
      end
      gsp_pkg::ST_DONE: ax <= '0;
      default: ax <= '0;
    endcase
  end

  assign busy = (state != gsp_pkg::ST_IDLE);
  assign done = (state == gsp_pkg::ST_DONE);
  assign surface_x = surf[0];
  assign surface_y = surf[1];
  assign surface_z = surf[2];
  assign steps_wide = {4'b0, steps};
  assign steps_used = steps_wide[3:0];
  assign status = origin ? gsp_pkg::STATUS_ORIGIN :
                  ((s_mag <= 64'(residual_tolerance)) ? gsp_pkg::STATUS_CONVERGED
                                                      : gsp_pkg::STATUS_LIMIT);

endmodule

/* design/gsp_checker.sv */
module gsp_checker #(
  parameter int COORD_WIDTH = 48
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic signed [COORD_WIDTH-1:0] surface_x,
  input logic signed [COORD_WIDTH-1:0] surface_y,
  input logic signed [COORD_WIDTH-1:0] surface_z,
  input logic [3:0]                    steps_used,
  input logic [1:0]                    status
);

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held longer than one cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("item accepted but busy not raised");

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result shown with no item in progress");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == gsp_pkg::STATUS_CONVERGED || status == gsp_pkg::STATUS_LIMIT ||
              status == gsp_pkg::STATUS_ORIGIN)) else $error("bad status code");

  a_origin_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == gsp_pkg::STATUS_ORIGIN) |->
      (surface_x == '0 && surface_y == '0 && surface_z == '0 && steps_used == '0))
    else $error("origin item gave nonzero result");

endmodule

bind geodetic_surface_projection_core gsp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_gsp_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .surface_x(surface_x), .surface_y(surface_y), .surface_z(surface_z),
  .steps_used(steps_used), .status(status)
);
